@@ hdl/rv64ic_pkg.sv @@
// Shared types and encoding constants for the RV64 instruction compressor.
package rv64ic_pkg;

  // Major opcodes of 32-bit instructions
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_32  = 7'h3b;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // funct3 codes of 32-bit instructions
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_DBL  = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [5:0] TOP6_LOGICAL = 6'h00;
  localparam logic [5:0] TOP6_ARITH   = 6'h10;

  // Register numbers with a special role
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  // Compressed quadrants
  localparam logic [1:0] Q0 = 2'b00;
  localparam logic [1:0] Q1 = 2'b01;
  localparam logic [1:0] Q2 = 2'b10;

  // Compressed funct3 codes
  localparam logic [2:0] CF3_ADDI4SPN = 3'b000;
  localparam logic [2:0] CF3_ADDI     = 3'b000;
  localparam logic [2:0] CF3_SLLI     = 3'b000;
  localparam logic [2:0] CF3_FLD      = 3'b001;
  localparam logic [2:0] CF3_LW       = 3'b010;
  localparam logic [2:0] CF3_LD       = 3'b011;
  localparam logic [2:0] CF3_LI       = 3'b010;
  localparam logic [2:0] CF3_LUI      = 3'b011;
  localparam logic [2:0] CF3_MISC_ALU = 3'b100;
  localparam logic [2:0] CF3_FSD      = 3'b101;
  localparam logic [2:0] CF3_SW       = 3'b110;
  localparam logic [2:0] CF3_SD       = 3'b111;

  // Sub-opcodes inside the misc-ALU group
  localparam logic [1:0] CALU_SRLI = 2'b00;
  localparam logic [1:0] CALU_SRAI = 2'b01;
  localparam logic [1:0] CALU_ANDI = 2'b10;
  localparam logic [1:0] CALU_REG  = 2'b11;

  localparam logic [1:0] CSEL_SUB = 2'd0;
  localparam logic [1:0] CSEL_XOR = 2'd1;
  localparam logic [1:0] CSEL_OR  = 2'd2;
  localparam logic [1:0] CSEL_AND = 2'd3;
  localparam logic [1:0] CSEL_SUBW = 2'd0;
  localparam logic [1:0] CSEL_ADDW = 2'd1;

  typedef struct packed {
    logic        compressible;
    logic [15:0] short_word;
  } result_t;

endpackage

@@ hdl/rv64ic_encoder.sv @@
// Combinational mapping of one 32-bit RV64 word to its compressed form.
module rv64ic_encoder (
  input  logic [31:0]        word,
  output rv64ic_pkg::result_t result
);

  function automatic logic [15:0] enc_imm6(input logic [2:0] f3, input logic [4:0] r,
                                           input logic [5:0] v);
    return {f3, v[5], r, v[4:0], rv64ic_pkg::Q1};
  endfunction

  function automatic logic [15:0] enc_cl_d(input logic [2:0] f3, input logic [11:0] off,
                                           input logic [2:0] b, input logic [2:0] r);
    return {f3, off[5:3], b, off[7:6], r, rv64ic_pkg::Q0};
  endfunction

  function automatic logic [15:0] enc_cl_w(input logic [2:0] f3, input logic [11:0] off,
                                           input logic [2:0] b, input logic [2:0] r);
    return {f3, off[5:3], b, off[2], off[6], r, rv64ic_pkg::Q0};
  endfunction

  function automatic logic [15:0] enc_ldsp(input logic [2:0] f3, input logic [11:0] off,
                                           input logic [4:0] r);
    return {f3, off[5], r, off[4:3], off[8:6], rv64ic_pkg::Q2};
  endfunction

  function automatic logic [15:0] enc_sdsp(input logic [2:0] f3, input logic [11:0] off,
                                           input logic [4:0] r);
    return {f3, off[5:3], off[8:6], r, rv64ic_pkg::Q2};
  endfunction

  logic [6:0]  opcode;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [5:0]  top6;
  logic [5:0]  shamt;
  logic [11:0] imm;
  logic [11:0] simm;
  logic        imm_fits6;
  logic        imm_zero;
  logic        lui_fits6;
  logic        rd_short;
  logic        rs1_short;
  logic        rs2_short;
  logic        rd_eq_rs1;
  // offset range checks, for load immediate and store immediate
  logic        ld_ok504, ld_ok248, ld_ok252, ld_ok124;
  logic        st_ok504, st_ok248, st_ok252, st_ok124;
  logic        ok;
  logic [15:0] hw;
  logic [1:0]  sel;

  assign opcode = word[6:0];
  assign rd     = word[11:7];
  assign f3     = word[14:12];
  assign rs1    = word[19:15];
  assign rs2    = word[24:20];
  assign f7     = word[31:25];
  assign top6   = word[31:26];
  assign shamt  = word[25:20];
  assign imm    = word[31:20];
  assign simm   = {word[31:25], word[11:7]};

  assign imm_fits6 = (imm[11:5] == '0) || (imm[11:5] == '1);
  assign imm_zero  = (imm == '0);
  // sign-extended 20-bit upper immediate lies in [-32, 31]
  assign lui_fits6 = (word[31:17] == '0) || (word[31:17] == '1);
  assign rd_short  = (rd[4:3] == 2'b01);
  assign rs1_short = (rs1[4:3] == 2'b01);
  assign rs2_short = (rs2[4:3] == 2'b01);
  assign rd_eq_rs1 = (rd == rs1);

  assign ld_ok504 = (imm[11:9] == '0) && (imm[2:0] == '0);
  assign ld_ok248 = (imm[11:8] == '0) && (imm[2:0] == '0);
  assign ld_ok252 = (imm[11:8] == '0) && (imm[1:0] == '0);
  assign ld_ok124 = (imm[11:7] == '0) && (imm[1:0] == '0);
  assign st_ok504 = (simm[11:9] == '0) && (simm[2:0] == '0);
  assign st_ok248 = (simm[11:8] == '0) && (simm[2:0] == '0);
  assign st_ok252 = (simm[11:8] == '0) && (simm[1:0] == '0);
  assign st_ok124 = (simm[11:7] == '0) && (simm[1:0] == '0);

  always_comb begin
    ok  = 1'b0;
    hw  = '0;
    sel = rv64ic_pkg::CSEL_SUB;
    case (opcode)
      rv64ic_pkg::OPC_LUI: begin
        if (rd != rv64ic_pkg::REG_ZERO && rd != rv64ic_pkg::REG_SP &&
            word[31:12] != '0 && lui_fits6) begin
          ok = 1'b1;
          hw = enc_imm6(rv64ic_pkg::CF3_LUI, rd, word[17:12]);
        end
      end
      rv64ic_pkg::OPC_OP_IMM: begin
        case (f3)
          rv64ic_pkg::F3_ADD: begin
            // first fit wins: nop, addi, addi16sp, addi4spn, li
            if (rd == rv64ic_pkg::REG_ZERO && rs1 == rv64ic_pkg::REG_ZERO && imm_zero) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_ADDI, 11'd0, rv64ic_pkg::Q1};
            end else if (rd_eq_rs1 && rd != rv64ic_pkg::REG_ZERO && !imm_zero && imm_fits6) begin
              ok = 1'b1;
              hw = enc_imm6(rv64ic_pkg::CF3_ADDI, rd, imm[5:0]);
            end else if (rd == rv64ic_pkg::REG_SP && rs1 == rv64ic_pkg::REG_SP && !imm_zero &&
                         imm[3:0] == '0 &&
                         (imm[11:9] == '0 || imm[11:9] == '1)) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_LUI, imm[9], rv64ic_pkg::REG_SP, imm[4], imm[6],
                    imm[8:7], imm[5], rv64ic_pkg::Q1};
            end else if (rs1 == rv64ic_pkg::REG_SP && rd_short && !imm_zero &&
                         imm[11:10] == '0 && imm[1:0] == '0) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_ADDI4SPN, imm[5:4], imm[9:6], imm[2], imm[3], rd[2:0],
                    rv64ic_pkg::Q0};
            end else if (rs1 == rv64ic_pkg::REG_ZERO && rd != rv64ic_pkg::REG_ZERO &&
                         imm_fits6) begin
              ok = 1'b1;
              hw = enc_imm6(rv64ic_pkg::CF3_LI, rd, imm[5:0]);
            end
          end
          rv64ic_pkg::F3_SLL: begin
            if (top6 == rv64ic_pkg::TOP6_LOGICAL && rd_eq_rs1 &&
                rd != rv64ic_pkg::REG_ZERO && shamt != '0) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_SLLI, shamt[5], rd, shamt[4:0], rv64ic_pkg::Q2};
            end
          end
          rv64ic_pkg::F3_SRL: begin
            if ((top6 == rv64ic_pkg::TOP6_LOGICAL || top6 == rv64ic_pkg::TOP6_ARITH) &&
                rd_eq_rs1 && rd_short && shamt != '0) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_MISC_ALU, shamt[5],
                    (top6 == rv64ic_pkg::TOP6_ARITH) ? rv64ic_pkg::CALU_SRAI
                                                     : rv64ic_pkg::CALU_SRLI,
                    rd[2:0], shamt[4:0], rv64ic_pkg::Q1};
            end
          end
          rv64ic_pkg::F3_AND: begin
            if (rd_eq_rs1 && rd_short && imm_fits6) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_MISC_ALU, imm[5], rv64ic_pkg::CALU_ANDI, rd[2:0],
                    imm[4:0], rv64ic_pkg::Q1};
            end
          end
          default: ok = 1'b0;
        endcase
      end
      rv64ic_pkg::OPC_OP: begin
        if (f7 == rv64ic_pkg::F7_BASE && f3 == rv64ic_pkg::F3_ADD) begin
          if (rd_eq_rs1 && rd != rv64ic_pkg::REG_ZERO && rs2 != rv64ic_pkg::REG_ZERO) begin
            ok = 1'b1;
            hw = {rv64ic_pkg::CF3_MISC_ALU, 1'b1, rd, rs2, rv64ic_pkg::Q2};
          end else if (rs1 == rv64ic_pkg::REG_ZERO && rd != rv64ic_pkg::REG_ZERO &&
                       rs2 != rv64ic_pkg::REG_ZERO) begin
            ok = 1'b1;
            hw = {rv64ic_pkg::CF3_MISC_ALU, 1'b0, rd, rs2, rv64ic_pkg::Q2};
          end
        end else if (rd_eq_rs1 && rd_short && rs2_short) begin
          ok = 1'b1;
          if (f7 == rv64ic_pkg::F7_BASE && f3 == rv64ic_pkg::F3_XOR) begin
            sel = rv64ic_pkg::CSEL_XOR;
          end else if (f7 == rv64ic_pkg::F7_BASE && f3 == rv64ic_pkg::F3_OR) begin
            sel = rv64ic_pkg::CSEL_OR;
          end else if (f7 == rv64ic_pkg::F7_BASE && f3 == rv64ic_pkg::F3_AND) begin
            sel = rv64ic_pkg::CSEL_AND;
          end else if (f7 == rv64ic_pkg::F7_ALT && f3 == rv64ic_pkg::F3_ADD) begin
            sel = rv64ic_pkg::CSEL_SUB;
          end else begin
            ok = 1'b0;
          end
          if (ok) begin
            hw = {rv64ic_pkg::CF3_MISC_ALU, 1'b0, rv64ic_pkg::CALU_REG, rd[2:0], sel,
                  rs2[2:0], rv64ic_pkg::Q1};
          end
        end
      end
      rv64ic_pkg::OPC_OP_32: begin
        if (f3 == rv64ic_pkg::F3_ADD && rd_eq_rs1 && rd_short && rs2_short &&
            (f7 == rv64ic_pkg::F7_BASE || f7 == rv64ic_pkg::F7_ALT)) begin
          ok = 1'b1;
          hw = {rv64ic_pkg::CF3_MISC_ALU, 1'b1, rv64ic_pkg::CALU_REG, rd[2:0],
                (f7 == rv64ic_pkg::F7_BASE) ? rv64ic_pkg::CSEL_ADDW : rv64ic_pkg::CSEL_SUBW,
                rs2[2:0], rv64ic_pkg::Q1};
        end
      end
      rv64ic_pkg::OPC_LOAD: begin
        if (f3 == rv64ic_pkg::F3_DBL) begin
          if (rs1 == rv64ic_pkg::REG_SP && rd != rv64ic_pkg::REG_ZERO) begin
            if (ld_ok504) begin
              ok = 1'b1;
              hw = enc_ldsp(rv64ic_pkg::CF3_LD, imm, rd);
            end
          end else if (rs1_short && rd_short && ld_ok248) begin
            ok = 1'b1;
            hw = enc_cl_d(rv64ic_pkg::CF3_LD, imm, rs1[2:0], rd[2:0]);
          end
        end else if (f3 == rv64ic_pkg::F3_WORD) begin
          if (rs1 == rv64ic_pkg::REG_SP && rd != rv64ic_pkg::REG_ZERO) begin
            if (ld_ok252) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_LW, imm[5], rd, imm[4:2], imm[7:6], rv64ic_pkg::Q2};
            end
          end else if (rs1_short && rd_short && ld_ok124) begin
            ok = 1'b1;
            hw = enc_cl_w(rv64ic_pkg::CF3_LW, imm, rs1[2:0], rd[2:0]);
          end
        end
      end
      rv64ic_pkg::OPC_STORE: begin
        if (f3 == rv64ic_pkg::F3_DBL) begin
          if (rs1 == rv64ic_pkg::REG_SP) begin
            if (st_ok504) begin
              ok = 1'b1;
              hw = enc_sdsp(rv64ic_pkg::CF3_SD, simm, rs2);
            end
          end else if (rs1_short && rs2_short && st_ok248) begin
            ok = 1'b1;
            hw = enc_cl_d(rv64ic_pkg::CF3_SD, simm, rs1[2:0], rs2[2:0]);
          end
        end else if (f3 == rv64ic_pkg::F3_WORD) begin
          if (rs1 == rv64ic_pkg::REG_SP) begin
            if (st_ok252) begin
              ok = 1'b1;
              hw = {rv64ic_pkg::CF3_SW, simm[5:2], simm[7:6], rs2, rv64ic_pkg::Q2};
            end
          end else if (rs1_short && rs2_short && st_ok124) begin
            ok = 1'b1;
            hw = enc_cl_w(rv64ic_pkg::CF3_SW, simm, rs1[2:0], rs2[2:0]);
          end
        end
      end
      rv64ic_pkg::OPC_LOAD_FP: begin
        if (f3 == rv64ic_pkg::F3_DBL) begin
          if (rs1 == rv64ic_pkg::REG_SP) begin
            if (ld_ok504) begin
              ok = 1'b1;
              hw = enc_ldsp(rv64ic_pkg::CF3_FLD, imm, rd);
            end
          end else if (rs1_short && rd_short && ld_ok248) begin
            ok = 1'b1;
            hw = enc_cl_d(rv64ic_pkg::CF3_FLD, imm, rs1[2:0], rd[2:0]);
          end
        end
      end
      rv64ic_pkg::OPC_STORE_FP: begin
        if (f3 == rv64ic_pkg::F3_DBL) begin
          if (rs1 == rv64ic_pkg::REG_SP) begin
            if (st_ok504) begin
              ok = 1'b1;
              hw = enc_sdsp(rv64ic_pkg::CF3_FSD, simm, rs2);
            end
          end else if (rs1_short && rs2_short && st_ok248) begin
            ok = 1'b1;
            hw = enc_cl_d(rv64ic_pkg::CF3_FSD, simm, rs1[2:0], rs2[2:0]);
          end
        end
      end
      rv64ic_pkg::OPC_JALR: begin
        if (f3 == rv64ic_pkg::F3_ADD && imm_zero && rs1 != rv64ic_pkg::REG_ZERO &&
            (rd == rv64ic_pkg::REG_ZERO || rd == rv64ic_pkg::REG_RA)) begin
          ok = 1'b1;
          hw = {rv64ic_pkg::CF3_MISC_ALU, rd[0], rs1, rv64ic_pkg::REG_ZERO, rv64ic_pkg::Q2};
        end
      end
      rv64ic_pkg::OPC_SYSTEM: begin
        if (word == rv64ic_pkg::WORD_EBREAK) begin
          ok = 1'b1;
          hw = {rv64ic_pkg::CF3_MISC_ALU, 1'b1, rv64ic_pkg::REG_ZERO, rv64ic_pkg::REG_ZERO,
                rv64ic_pkg::Q2};
        end
      end
      default: ok = 1'b0;
    endcase
  end

  assign result.compressible = ok;
  assign result.short_word   = ok ? hw : '0;

endmodule

@@ hdl/rv64_instruction_compressor_core.sv @@
// Top level of the RV64 instruction compressor: input register, encoder, result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   input    | in_valid / in_ready  | instr_word[31:0]
//   output   | out_valid / out_ready| compressible, short_word[15:0]
//
// One word per cycle while the output accepts; a result passes through the input register,
// the encoder logic and the result register in that order before it is offered on the output.
// Synchronous active-high rst empties both stages; payload registers are not reset.
// A stall on the output holds the result register and backs up into the input
// register; each stage refills in the cycle its content moves on.
module rv64_instruction_compressor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        compressible,
  output logic [15:0] short_word
);

  logic                word_valid;
  logic [31:0]         word;
  logic                res_valid;
  rv64ic_pkg::result_t res;
  rv64ic_pkg::result_t enc_result;
  logic                res_load;
  logic                word_load;

  rv64ic_encoder u_encoder (
    .word   (word),
    .result (enc_result)
  );

  // advance a stage when it is empty or its content moves on this cycle
  assign res_load  = !res_valid || out_ready;
  assign in_ready  = !word_valid || res_load;
  assign word_load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        word_valid <= in_valid;
      end
      if (res_load) begin
        res_valid <= word_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_load) begin
      word <= instr_word;
    end
    if (res_load && word_valid) begin
      res <= enc_result;
    end
  end

  assign out_valid    = res_valid;
  assign compressible = res.compressible;
  assign short_word   = res.short_word;

endmodule
